FILE: rtl/spike_to_fluorescence_model_top_macros.svh
`ifndef SPIKE_TO_FLUORESCENCE_MODEL_TOP_MACROS_SVH
`define SPIKE_TO_FLUORESCENCE_MODEL_TOP_MACROS_SVH

// same-cycle implication, checked on clk_i outside reset
`define STFM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i outside reset
`define STFM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/stfm_pkg.sv
package stfm_pkg;

  localparam int unsigned NEURONS   = 32;
  localparam int unsigned NIDX_W    = 5;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned PROD_W    = CFG_W + VAL_W;
  localparam int unsigned ADD_W     = CFG_W + CNT_W;
  localparam int unsigned FRAC_W    = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // input op codes
  localparam logic OP_SPIKE = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd2;

  // frame value modes, anything else is the leaky integrator
  localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACTIVE = 2'd1;

  localparam logic [MODE_W-1:0] RESET_MODE  = MODE_COUNT;
  localparam logic [CFG_W-1:0]  RESET_DECAY = 16'd58982;
  localparam logic [CFG_W-1:0]  RESET_GAIN  = 16'd256;

  typedef struct packed {
    logic spk_acc;
    logic sw_rd;
    logic sw_mul;
    logic sw_commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic sw_last;
  } sts_t;

endpackage

FILE: rtl/stfm_dp.sv
`include "spike_to_fluorescence_model_top_macros.svh"

module stfm_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [stfm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [stfm_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic [stfm_pkg::NIDX_W-1:0]      neuron_i,
  input  stfm_pkg::cmd_t                   cmd_i,
  output stfm_pkg::sts_t                   sts_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [stfm_pkg::NIDX_W-1:0]      neuron_out_o,
  output logic [stfm_pkg::VAL_W-1:0]       frame_value_o,
  output logic                             last_o
);

  // configuration
  logic [stfm_pkg::MODE_W-1:0] mode_q;
  logic [stfm_pkg::CFG_W-1:0]  decay_q;
  logic [stfm_pkg::CFG_W-1:0]  gain_q;

  // stores and their valid bits
  logic [stfm_pkg::CNT_W-1:0]  cnt_mem [stfm_pkg::NEURONS];
  logic [stfm_pkg::VAL_W-1:0]  cal_mem [stfm_pkg::NEURONS];
  logic [stfm_pkg::NEURONS-1:0] cnt_vld_q;
  logic [stfm_pkg::NEURONS-1:0] cal_vld_q;

  // read side
  logic                        rd_en;
  logic [stfm_pkg::NIDX_W-1:0] rd_addr;
  logic [stfm_pkg::CNT_W-1:0]  cnt_rd_q;
  logic                        cnt_vld_rd_q;
  logic [stfm_pkg::VAL_W-1:0]  cal_rd_q;
  logic                        cal_vld_rd_q;
  logic                        fwd_q;
  logic [stfm_pkg::CNT_W-1:0]  fwd_data_q;

  // spike write stage
  logic                        spk_q;
  logic                        spk_inr_q;
  logic [stfm_pkg::NIDX_W-1:0] spk_idx_q;
  logic                        cnt_we;
  logic [stfm_pkg::CNT_W-1:0]  cnt_cur;
  logic [stfm_pkg::CNT_W-1:0]  cnt_inc;

  // sweep
  logic [stfm_pkg::NIDX_W-1:0] sw_idx_q;
  logic [stfm_pkg::NIDX_W-1:0] sw_idx_d;
  logic                        sw_last;
  logic [stfm_pkg::VAL_W-1:0]  level;
  logic [stfm_pkg::PROD_W-1:0] dec_prod_q;
  logic [stfm_pkg::ADD_W-1:0]  add_q;
  logic [stfm_pkg::VAL_W:0]    sum;
  logic [stfm_pkg::VAL_W-1:0]  cal_new;
  logic [stfm_pkg::VAL_W-1:0]  value;

  // output register
  logic                        out_vld_q;
  logic                        out_free;
  logic [stfm_pkg::NIDX_W-1:0] nout_q;
  logic [stfm_pkg::VAL_W-1:0]  fval_q;
  logic                        last_q;

  assign rd_en   = cmd_i.spk_acc | cmd_i.sw_rd;
  assign rd_addr = cmd_i.sw_rd ? sw_idx_q : neuron_i;

  assign cnt_cur = fwd_q ? fwd_data_q : (cnt_vld_rd_q ? cnt_rd_q : '0);
  assign cnt_inc = (cnt_cur == stfm_pkg::CNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
  assign cnt_we  = spk_q & spk_inr_q;

  assign sw_last  = (sw_idx_q == stfm_pkg::NIDX_W'(stfm_pkg::NEURONS - 1));
  assign sw_idx_d = sw_last ? '0 : sw_idx_q + 1'b1;

  assign level   = cal_vld_rd_q ? cal_rd_q : '0;
  assign sum     = {1'b0, dec_prod_q[stfm_pkg::PROD_W-1:stfm_pkg::FRAC_W]}
                 + {1'b0, add_q, 8'h00};
  assign cal_new = sum[stfm_pkg::VAL_W] ? '1 : sum[stfm_pkg::VAL_W-1:0];

  always_comb begin
    case (mode_q)
      stfm_pkg::MODE_COUNT:  value = {8'h00, cnt_cur, 16'h0000};
      stfm_pkg::MODE_ACTIVE: value = (cnt_cur != '0) ? 32'h0001_0000 : '0;
      default:               value = cal_new;
    endcase
  end

  assign out_free = ~out_vld_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= stfm_pkg::RESET_MODE;
      decay_q   <= stfm_pkg::RESET_DECAY;
      gain_q    <= stfm_pkg::RESET_GAIN;
      cnt_vld_q <= '0;
      cal_vld_q <= '0;
      spk_q     <= 1'b0;
      fwd_q     <= 1'b0;
      sw_idx_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          stfm_pkg::REG_MODE:  mode_q  <= cfg_data_i[stfm_pkg::MODE_W-1:0];
          stfm_pkg::REG_DECAY: decay_q <= cfg_data_i;
          stfm_pkg::REG_GAIN:  gain_q  <= cfg_data_i;
          default: ;
        endcase
      end
      spk_q <= cmd_i.spk_acc;
      if (rd_en) begin
        // a spike read racing the write of the previous spike to the same neuron
        fwd_q <= cnt_we & (spk_idx_q == rd_addr);
      end
      if (cnt_we) begin
        cnt_vld_q[spk_idx_q] <= 1'b1;
      end
      if (cmd_i.sw_commit) begin
        cnt_vld_q[sw_idx_q] <= 1'b0;
        cal_vld_q[sw_idx_q] <= 1'b1;
        sw_idx_q            <= sw_idx_d;
        out_vld_q           <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.spk_acc) begin
      spk_idx_q <= neuron_i;
      spk_inr_q <= ({1'b0, neuron_i} < (stfm_pkg::NIDX_W + 1)'(stfm_pkg::NEURONS));
    end
    if (cnt_we) begin
      cnt_mem[spk_idx_q] <= cnt_inc;
    end
    if (rd_en) begin
      cnt_rd_q     <= cnt_mem[rd_addr];
      cnt_vld_rd_q <= cnt_vld_q[rd_addr];
      fwd_data_q   <= cnt_inc;
    end
    if (cmd_i.sw_commit) begin
      cal_mem[sw_idx_q] <= cal_new;
    end
    if (cmd_i.sw_rd) begin
      cal_rd_q     <= cal_mem[sw_idx_q];
      cal_vld_rd_q <= cal_vld_q[sw_idx_q];
    end
    if (cmd_i.sw_mul) begin
      dec_prod_q <= decay_q * level;
      add_q      <= gain_q * cnt_cur;
    end
    if (cmd_i.sw_commit) begin
      nout_q <= sw_idx_q;
      fval_q <= value;
      last_q <= sw_last;
    end
  end

  assign sts_o.out_free = out_free;
  assign sts_o.sw_last  = sw_last;

  assign out_valid_o   = out_vld_q;
  assign neuron_out_o  = nout_q;
  assign frame_value_o = fval_q;
  assign last_o        = last_q;

  `STFM_ASSERT_IMP(a_rd_no_pending_spk, cmd_i.sw_rd, !spk_q, "sweep read overlaps spike write")
  `STFM_ASSERT_IMP(a_mul_after_rd, cmd_i.sw_mul, $past(cmd_i.sw_rd), "multiply without read")
  `STFM_ASSERT_NXT(a_commit_loads_out, cmd_i.sw_commit, out_vld_q, "commit lost")
  `STFM_ASSERT_NXT(a_sweep_wraps, cmd_i.sw_commit && sw_last, sw_idx_q == '0, "sweep did not wrap")

endmodule

FILE: rtl/stfm_ctrl.sv
module stfm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           op_i,
  input  stfm_pkg::sts_t sts_i,
  output stfm_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_MUL  = 4'b0100,
    S_SUM  = 4'b1000
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i & in_ready_o;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.spk_acc   = acc & (op_i == stfm_pkg::OP_SPIKE);
    case (state_q)
      S_IDLE: begin
        if (acc && op_i == stfm_pkg::OP_FRAME) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.sw_rd = 1'b1;
        state_d     = S_MUL;
      end
      S_MUL: begin
        cmd_o.sw_mul = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        if (sts_i.out_free) begin
          cmd_o.sw_commit = 1'b1;
          state_d         = sts_i.sw_last ? S_IDLE : S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/spike_to_fluorescence_model_top.sv
// channel  direction  handshake                    payload
// in       sink       in_valid_i / in_ready_o      op_i, neuron_i
// out      source     out_valid_o / out_ready_i    neuron_out_o, frame_value_o, last_o
// cfg      sink       cfg_we_i (no wait)           cfg_idx_i, cfg_data_i
//
// a spike item is taken in the idle state; spikes may arrive back to back outside a sweep
// a frame-end item starts a sweep over all NEURONS neurons; no item is taken until it ends:
//   the sweep reads, multiplies and sums one neuron at a time through one shared unit
// a result may wait in the output register while the sweep reads and multiplies the next neuron;
//   if it is still there then, the sweep holds at its sum step until the output is free
// reset is asynchronous, active low; counts and levels read as zero via valid bits

module spike_to_fluorescence_model_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // item input
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           op_i,
  input  logic [stfm_pkg::NIDX_W-1:0]    neuron_i,
  // result output
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [stfm_pkg::NIDX_W-1:0]    neuron_out_o,
  output logic [stfm_pkg::VAL_W-1:0]     frame_value_o,
  output logic                           last_o,
  // register writes
  input  logic                           cfg_we_i,
  input  logic [stfm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [stfm_pkg::CFG_W-1:0]     cfg_data_i
);

  // commands from the sequencer, status back from the datapath
  stfm_pkg::cmd_t cmd;
  stfm_pkg::sts_t sts;

  // sequencer: takes items, steps the frame sweep one neuron at a time
  stfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: count and level stores, multipliers, saturating sum, output register
  stfm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .neuron_i      (neuron_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .neuron_out_o  (neuron_out_o),
    .frame_value_o (frame_value_o),
    .last_o        (last_o)
  );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import stfm_pkg::*;

  // spare register index, writes there must leave every register alone
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned TAIL_CYCLES     = 16;
  localparam int unsigned RANDOM_PHASES   = 4;
  localparam int unsigned ITEMS_PER_PHASE = 47;

  // one frame value as it leaves the block
  typedef struct packed {
    logic [NIDX_W-1:0] nrn;
    logic [VAL_W-1:0]  value;
    logic              last;
  } frame_result_t;

  // per-neuron spike counter and calcium integrator, plus the queue of frame values due
  class frame_scoreboard;
    logic [CNT_W-1:0]  spike_counts [NEURONS];
    logic [VAL_W-1:0]  calcium [NEURONS];
    logic [MODE_W-1:0] mode;
    logic [CFG_W-1:0]  decay;
    logic [CFG_W-1:0]  gain;
    frame_result_t     results_due [$];
    int unsigned       errors;

    function new();
      foreach (spike_counts[i]) begin
        spike_counts[i] = '0;
        calcium[i]      = '0;
      end
      mode   = RESET_MODE;
      decay  = RESET_DECAY;
      gain   = RESET_GAIN;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_MODE:  mode  = data[MODE_W-1:0];
        REG_DECAY: decay = data;
        REG_GAIN:  gain  = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    function void note_item(logic op, logic [NIDX_W-1:0] nrn);
      logic [PROD_W-1:0] decayed;
      logic [VAL_W:0]    level;
      frame_result_t     r;
      if (op == OP_SPIKE) begin
        if (spike_counts[nrn] != CNT_MAX) spike_counts[nrn] = spike_counts[nrn] + 1'b1;
        return;
      end
      // frame end: every level moves on, whatever the mode
      for (int i = 0; i < NEURONS; i++) begin
        decayed = PROD_W'(decay) * PROD_W'(calcium[i]);
        level = (VAL_W+1)'(decayed >> FRAC_W)
              + (((VAL_W+1)'(gain) * (VAL_W+1)'(spike_counts[i])) << 8);
        calcium[i] = level[VAL_W] ? '1 : level[VAL_W-1:0];
        case (mode)
          MODE_COUNT:  r.value = VAL_W'(spike_counts[i]) << FRAC_W;
          MODE_ACTIVE: r.value = (spike_counts[i] != '0) ? (VAL_W'(1) << FRAC_W) : '0;
          default:     r.value = calcium[i];
        endcase
        r.nrn  = NIDX_W'(i);
        r.last = (i == NEURONS - 1);
        results_due.push_back(r);
        spike_counts[i] = '0;
      end
    endfunction

    task flag_mismatch(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(logic [NIDX_W-1:0] nrn, logic [VAL_W-1:0] value, logic last);
      frame_result_t want;
      if (results_due.size() == 0) begin
        flag_mismatch($sformatf("result for neuron %0d with nothing due", nrn));
        return;
      end
      want = results_due.pop_front();
      if (nrn !== want.nrn)
        flag_mismatch($sformatf("neuron_out got %0d want %0d", nrn, want.nrn));
      if (value !== want.value)
        flag_mismatch($sformatf("frame_value of neuron %0d got %h want %h",
                                want.nrn, value, want.value));
      if (last !== want.last)
        flag_mismatch($sformatf("last of neuron %0d got %b want %b", want.nrn, last, want.last));
    endtask
  endclass

  // clock, reset and block inputs, all known from time zero
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 op_i        = OP_SPIKE;
  logic [NIDX_W-1:0]    neuron_i    = '0;
  logic                 out_ready_i = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = REG_MODE;
  logic [CFG_W-1:0]     cfg_data_i  = '0;

  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [NIDX_W-1:0]    neuron_out_o;
  logic [VAL_W-1:0]     frame_value_o;
  logic                 last_o;

  frame_scoreboard sb;
  logic            idle_on    = 1'b1;
  int unsigned     stall_left = 0;
  int unsigned     cycles     = 0;

  spike_to_fluorescence_model_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .neuron_i      (neuron_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .neuron_out_o  (neuron_out_o),
    .frame_value_o (frame_value_o),
    .last_o        (last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // receiver stalls in random bursts while idling is on
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // every accepted frame value goes straight to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i)
      sb.check_result(neuron_out_o, frame_value_o, last_o);
  end

  // offer one item, maybe after a short gap, and hold it until taken
  task automatic push_item(input logic op, input logic [NIDX_W-1:0] nrn);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    neuron_i   <= nrn;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_item(op, nrn);
  endtask

  // drop valid, let every frame value come out, then give the sweep time to settle
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] mode_word, input logic [CFG_W-1:0] decay,
                          input logic [CFG_W-1:0] gain);
    write_reg(REG_MODE, mode_word);
    write_reg(REG_DECAY, decay);
    write_reg(REG_GAIN, gain);
  endtask

  // decay and gain lean towards their extremes
  function automatic logic [CFG_W-1:0] pick_factor();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return CFG_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [NIDX_W-1:0] hot;
    sb = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, count mode: the very first spike must count
    push_item(OP_SPIKE, 5'd0);
    push_item(OP_SPIKE, 5'd0);
    push_item(OP_SPIKE, 5'd31);
    push_item(OP_SPIKE, 5'd21);
    push_item(OP_FRAME, 5'd31);
    // a frame with no spikes at all, levels only decay
    push_item(OP_FRAME, 5'd0);

    // active flag, upper mode bits set, write to the spare index ignored
    wait_idle();
    write_reg(REG_MODE, 16'hFFFD);
    write_reg(REG_SPARE, 16'hFFFF);
    push_item(OP_SPIKE, 5'd31);
    push_item(OP_SPIKE, 5'd10);
    push_item(OP_SPIKE, 5'd10);
    push_item(OP_FRAME, 5'd10);

    // leaky with no decay and full gain, then an empty frame wipes the level
    wait_idle();
    set_regs(16'h0002, 16'h0000, 16'hFFFF);
    push_item(OP_SPIKE, 5'd3);
    push_item(OP_SPIKE, 5'd3);
    push_item(OP_FRAME, 5'd3);
    push_item(OP_FRAME, 5'd0);

    // unused mode behaves as leaky; full decay and zero gain nearly hold levels
    wait_idle();
    set_regs(16'h0003, 16'hFFFF, 16'h0000);
    push_item(OP_SPIKE, 5'd1);
    push_item(OP_FRAME, 5'd1);

    // back to reset factors, leaky mode
    wait_idle();
    set_regs(16'hFFFE, RESET_DECAY, RESET_GAIN);
    push_item(OP_SPIKE, 5'd4);
    push_item(OP_FRAME, 5'd4);

    // random phases, each with fresh settings; last phase without idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      set_regs(CFG_W'($urandom), pick_factor(), pick_factor());
      idle_on = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      hot = NIDX_W'($urandom);
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 7) == 0)
          push_item(OP_FRAME, NIDX_W'($urandom));
        else if ($urandom_range(0, 1) == 0)
          push_item(OP_SPIKE, hot ^ NIDX_W'($urandom_range(0, 1)));
        else
          push_item(OP_SPIKE, NIDX_W'($urandom));
      end
      // close each phase on a frame so its spikes are seen
      push_item(OP_FRAME, NIDX_W'($urandom));
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
